>>> rtl/core/asr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// asr_pkg
// Shared types and constants for the alternate-sign rearrange block.
// ----------------------------------------------------------------------------
package asr_pkg;

    localparam int unsigned ELEM_W = 32;
    localparam int unsigned SIGN_BIT = ELEM_W - 1;

    typedef struct packed {
        logic signed [ELEM_W-1:0] element;
        logic                     is_last;
    } asr_in_t;

    typedef struct packed {
        logic signed [ELEM_W-1:0] element_res;
        logic                     is_last_res;
    } asr_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_ROTATE,
        ST_PLACE,
        ST_EMIT
    } asr_state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic scan_rd;
        logic eval;
        logic rot_step;
        logic place;
        logic emit;
    } asr_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic load_end;
        logic need_rot;
        logic rot_done;
        logic scan_end;
        logic emit_end;
    } asr_status_t;

endpackage
`default_nettype wire

>>> rtl/core/alternate_sign_rearrange.sv
`default_nettype none
// Each item is taken when start is high while busy is low, so items can come
// back to back. The item marked last (or the one that fills MAX_LEN slots)
// starts the rearrangement: each scanned position is read, then evaluated;
// a rotation shifts one element at a time through the single-port-write
// store, then places the held element; the results then stream out.
// Results cannot be stalled. Reset clears control state only; the store does not.
// ----------------------------------------------------------------------------
// alternate_sign_rearrange
// Collects a list of signed values, reorders it in place so negatives sit at
// even positions and non-negatives at odd positions (stable within each sign),
// then streams it out with a last marker.
// ----------------------------------------------------------------------------
module alternate_sign_rearrange
    import asr_pkg::*;
#(
    parameter int unsigned MAX_LEN = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire asr_in_t     item,
    output logic             busy,
    output asr_out_t         result,
    output logic             result_valid
);

    // Command and status between the sequencer and the datapath
    asr_cmd_t    cmd;
    asr_status_t status;

    // Sequencer: accept a transfer while idle, then walk the scan, each
    // rotation one shifted element per cycle, and finally the emit sweep.
    asr_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // Datapath: store, indexes, and the registered result valid flag.
    asr_datapath #(
        .MAX_LEN (MAX_LEN)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .status       (status),
        .result       (result),
        .result_valid (result_valid)
    );

endmodule
`default_nettype wire

>>> rtl/core/asr_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// asr_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module asr_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

>>> rtl/core/asr_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// asr_ctrl
// Sequencer: load, scan, rotate, place, emit.
// ----------------------------------------------------------------------------
module asr_ctrl
    import asr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire asr_status_t status,
    output asr_cmd_t         cmd,
    output logic             busy
);

    asr_state_t state_reg;
    asr_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load = 1'b1;
                    if (status.load_end)
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                cmd.scan_rd = 1'b1;
                state_next  = ST_EVAL;
            end
            ST_EVAL:
            begin
                cmd.eval = 1'b1;
                if (status.need_rot)
                begin
                    state_next = ST_ROTATE;
                end
                else if (status.scan_end)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_READ;
                end
            end
            ST_ROTATE:
            begin
                cmd.rot_step = 1'b1;
                if (status.rot_done)
                begin
                    state_next = ST_PLACE;
                end
            end
            ST_PLACE:
            begin
                cmd.place  = 1'b1;
                state_next = status.scan_end ? ST_EMIT : ST_READ;
            end
            ST_EMIT:
            begin
                cmd.emit = 1'b1;
                if (status.emit_end)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> rtl/core/asr_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// asr_datapath
// List store, scan/misplaced/rotate indexes and result register.
// ----------------------------------------------------------------------------
module asr_datapath
    import asr_pkg::*;
#(
    parameter int unsigned MAX_LEN = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire asr_in_t     item,
    input  wire asr_cmd_t    cmd,
    output asr_status_t      status,
    output asr_out_t         result,
    output logic             result_valid
);

    localparam int unsigned AW = $clog2(MAX_LEN);
    localparam int unsigned CW = $clog2(MAX_LEN + 1);

    logic [CW-1:0]     count_reg,     count_next;
    logic [AW-1:0]     scan_reg,      scan_next;
    logic [AW-1:0]     mis_reg,       mis_next;
    logic              mis_valid_reg, mis_valid_next;
    logic              msign_reg,     msign_next;
    logic [AW-1:0]     rot_reg,       rot_next;
    logic [AW-1:0]     emit_reg,      emit_next;
    logic [ELEM_W-1:0] held_reg,      held_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_last_reg,  out_last_next;

    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [ELEM_W-1:0] wr_data;
    logic [AW-1:0]     rd_addr;
    logic [ELEM_W-1:0] rd_data;
    logic              rd_neg;

    asr_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (MAX_LEN)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_neg = rd_data[SIGN_BIT];

    always_comb
    begin
        status.load_end = item.is_last || (count_reg + CW'(1) == CW'(MAX_LEN));
        status.need_rot = mis_valid_reg && (rd_neg != msign_reg);
        status.rot_done = (rot_reg - AW'(1)) == mis_reg;
        status.scan_end = (CW'(scan_reg) + CW'(1)) == count_reg;
        status.emit_end = (CW'(emit_reg) + CW'(1)) == count_reg;
    end

    // Store port steering
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = count_reg[AW-1:0];
        wr_data = item.element;
        rd_addr = emit_reg;
        if (cmd.load)
        begin
            wr_en = 1'b1;
        end
        if (cmd.rot_step)
        begin
            wr_en   = 1'b1;
            wr_addr = rot_reg;
            wr_data = rd_data;
            rd_addr = rot_reg - AW'(2);
        end
        if (cmd.place)
        begin
            wr_en   = 1'b1;
            wr_addr = mis_reg;
            wr_data = held_reg;
        end
        if (cmd.scan_rd)
        begin
            rd_addr = scan_reg;
        end
        if (cmd.eval)
        begin
            rd_addr = scan_reg - AW'(1);
        end
    end

    always_comb
    begin
        count_next     = count_reg;
        scan_next      = scan_reg;
        mis_next       = mis_reg;
        mis_valid_next = mis_valid_reg;
        msign_next     = msign_reg;
        rot_next       = rot_reg;
        emit_next      = emit_reg;
        held_next      = held_reg;
        out_valid_next = 1'b0;
        out_last_next  = 1'b0;

        if (cmd.load)
        begin
            count_next = count_reg + CW'(1);
        end

        if (cmd.eval)
        begin
            if (status.need_rot)
            begin
                // hold the opposite-sign element, shift from the scan slot down
                held_next = rd_data;
                rot_next  = scan_reg;
            end
            else
            begin
                if (!mis_valid_reg && (rd_neg == scan_reg[0]))
                begin
                    mis_next       = scan_reg;
                    mis_valid_next = 1'b1;
                    msign_next     = rd_neg;
                end
                scan_next = scan_reg + AW'(1);
            end
        end

        if (cmd.rot_step)
        begin
            rot_next = rot_reg - AW'(1);
        end

        if (cmd.place)
        begin
            if ((scan_reg - mis_reg) != AW'(1))
            begin
                mis_next = mis_reg + AW'(2);
            end
            else if (msign_reg == scan_reg[0])
            begin
                // the slot at scan now holds the old misplaced value
                mis_next = scan_reg;
            end
            else
            begin
                mis_next       = '0;
                mis_valid_next = 1'b0;
            end
            scan_next = scan_reg + AW'(1);
        end

        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            out_last_next  = status.emit_end;
            emit_next      = emit_reg + AW'(1);
            if (status.emit_end)
            begin
                count_next     = '0;
                scan_next      = '0;
                mis_next       = '0;
                mis_valid_next = 1'b0;
                emit_next      = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            scan_reg      <= '0;
            mis_reg       <= '0;
            mis_valid_reg <= 1'b0;
            msign_reg     <= 1'b0;
            rot_reg       <= '0;
            emit_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            scan_reg      <= scan_next;
            mis_reg       <= mis_next;
            mis_valid_reg <= mis_valid_next;
            msign_reg     <= msign_next;
            rot_reg       <= rot_next;
            emit_reg      <= emit_next;
            out_valid_reg <= out_valid_next;
            out_last_reg  <= out_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_reg <= held_next;
    end

    assign result.element_res = rd_data;
    assign result.is_last_res = out_last_reg;
    assign result_valid       = out_valid_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_LEN))
        else $error("list count beyond capacity");

    a_mis_behind_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.eval && mis_valid_reg |-> mis_reg < scan_reg)
        else $error("misplaced slot not behind scan position");

    a_rot_above_mis: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rot_step |-> rot_reg > mis_reg)
        else $error("rotation passed the misplaced slot");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit && status.emit_end |=> count_reg == '0 && !mis_valid_reg)
        else $error("list state not cleared after last transfer");

endmodule
`default_nettype wire

>>> dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for alternate_sign_rearrange. A queue of list elements
// feeds a falling-edge driver with random gaps. A rising-edge monitor keeps an
// independent model of the in-place sign rearrangement and checks every
// emitted element and its last flag in order.
// ----------------------------------------------------------------------------
module tb;
    import asr_pkg::*;

    localparam int unsigned LIST_CAP     = 64;
    localparam int unsigned MAX_GAP      = 13;
    localparam int unsigned RANDOM_ITEMS = 25;
    localparam int unsigned DRAIN_CYCLES = 300;
    localparam int unsigned MAX_REPORTS  = 10;
    // Time limit, many times the length of the whole run.
    localparam longint unsigned LIMIT_NS = 2_000_000;

    typedef struct {
        asr_in_t     data;
        int unsigned gap;
    } feed_entry_t;

    logic     clk;
    logic     rst_n = 1'b0;
    logic     start = 1'b0;
    asr_in_t  drv_item = '0;
    logic     busy;
    asr_out_t result;
    logic     result_valid;

    // Items still to be driven, and results the model says must come out.
    feed_entry_t list_feed_q[$];
    asr_out_t    rearranged_q[$];

    // Shadow copy of the list being collected.
    logic [ELEM_W-1:0] list_buf [LIST_CAP];
    int unsigned       list_len = 0;

    int unsigned mismatch_count = 0;
    int unsigned gap_done = 0;
    logic        took = 1'b0;
    bit          burst_mode = 1'b0;

    alternate_sign_rearrange #(
        .MAX_LEN (LIST_CAP)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .item         (drv_item),
        .busy         (busy),
        .result       (result),
        .result_valid (result_valid)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // ------------------------------------------------------------------
    // Model
    // ------------------------------------------------------------------

    // Scan from the front; remember the first slot whose sign is wrong for its
    // parity, and when a later element of the other sign shows up, rotate the
    // span right by one so that element lands in the hole.
    task automatic reorder_list();
        int unsigned       hole;
        bit                hole_set;
        int unsigned       pos;
        int unsigned       j;
        logic [ELEM_W-1:0] held;
        hole = 0;
        hole_set = 1'b0;
        for (pos = 0; pos < list_len; pos++)
        begin
            if (hole_set && (list_buf[pos][SIGN_BIT] != list_buf[hole][SIGN_BIT]))
            begin
                held = list_buf[pos];
                for (j = pos; j > hole; j--)
                    list_buf[j] = list_buf[j-1];
                list_buf[hole] = held;
                // The hole moves two ahead while the span is long enough;
                // a span of one closes it.
                if (pos - hole >= 2)
                    hole = hole + 2;
                else
                begin
                    hole_set = 1'b0;
                    hole = 0;
                end
            end
            // Negatives belong at even slots, zero and positives at odd ones.
            if (!hole_set && (list_buf[pos][SIGN_BIT] == pos[0]))
            begin
                hole = pos;
                hole_set = 1'b1;
            end
        end
    endtask

    // Take one accepted element; on the end of a list, reorder and queue the
    // whole list as expected output.
    task automatic absorb_element(input asr_in_t it);
        asr_out_t    exp;
        int unsigned k;
        list_buf[list_len] = it.element;
        list_len++;
        // A full store closes the list whatever the last flag says.
        if (it.is_last || list_len >= LIST_CAP)
        begin
            reorder_list();
            for (k = 0; k < list_len; k++)
            begin
                exp.element_res = list_buf[k];
                exp.is_last_res = (k + 1 == list_len);
                rearranged_q.push_back(exp);
            end
            list_len = 0;
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic int unsigned draw_gap();
        if (burst_mode)
            return 0;
        return $urandom_range(0, MAX_GAP);
    endfunction

    task automatic queue_elem(input logic [ELEM_W-1:0] v, input bit last);
        feed_entry_t e;
        e.data.element = v;
        e.data.is_last = last;
        e.gap = draw_gap();
        list_feed_q.push_back(e);
    endtask

    // Random value with the sign drawn from neg_pct; now and then an extreme.
    function automatic logic [ELEM_W-1:0] pick_value(input int unsigned neg_pct);
        logic [ELEM_W-1:0] v;
        bit                neg;
        neg = ($urandom_range(0, 99) < neg_pct);
        case ($urandom_range(0, 11))
            0:       v = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
            1:       v = neg ? 32'hFFFF_FFFF : 32'h0000_0000;
            2:       v = neg ? 32'hFFFF_FFFF - $urandom_range(0, 15) : $urandom_range(0, 15);
            default:
            begin
                v = $urandom;
                v[SIGN_BIT] = neg;
            end
        endcase
        return v;
    endfunction

    // One list of len elements; close_flag sets the flag on the final one
    // (a full list ends even with the flag clear).
    task automatic queue_list(input int unsigned len, input bit close_flag);
        int unsigned neg_pct;
        int unsigned k;
        case ($urandom_range(0, 7))
            0:       neg_pct = 0;
            1:       neg_pct = 100;
            2:       neg_pct = 10;
            3:       neg_pct = 90;
            default: neg_pct = $urandom_range(20, 80);
        endcase
        burst_mode = ($urandom_range(0, 3) == 0);
        for (k = 0; k < len; k++)
            queue_elem(pick_value(neg_pct), (k + 1 == len) ? close_flag : 1'b0);
    endtask

    // ------------------------------------------------------------------
    // Driver: present the head of the feed queue, hold it until the
    // transfer, then wait out the next entry's gap.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else if (start && !took)
        begin
            // hold: the block has not taken the item yet
        end
        else if (list_feed_q.size() == 0)
            start <= 1'b0;
        else if (gap_done < list_feed_q[0].gap)
        begin
            start <= 1'b0;
            gap_done++;
        end
        else
        begin
            drv_item <= list_feed_q[0].data;
            start <= 1'b1;
            list_feed_q.pop_front();
            gap_done = 0;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: log each input transfer into the model, then check any result
    // against the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        asr_out_t exp;
        bit       xfer;
        xfer = rst_n && start && !busy;
        took <= xfer;
        if (xfer)
            absorb_element(drv_item);
        if (rst_n && result_valid)
        begin
            if (rearranged_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result: element %0d last %0b",
                             result.element_res, result.is_last_res);
            end
            else
            begin
                exp = rearranged_q.pop_front();
                if (result.element_res !== exp.element_res ||
                    result.is_last_res !== exp.is_last_res)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("mismatch: expected element %0d last %0b, got element %0d last %0b",
                                 exp.element_res, exp.is_last_res,
                                 result.element_res, result.is_last_res);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned random_sent;
        int unsigned len;

        // Directed lists: lone elements of each sign, the two extremes,
        // zero as a non-negative, single-sign lists with no partner to swap
        // in, and a block of positives followed by a block of negatives.
        queue_elem(32'd5, 1'b1);
        queue_elem(-32'sd7, 1'b1);
        queue_elem(32'h7FFF_FFFF, 1'b0);
        queue_elem(32'h8000_0000, 1'b1);
        queue_elem(32'd0, 1'b0);
        queue_elem(32'hFFFF_FFFF, 1'b0);
        queue_elem(32'd0, 1'b0);
        queue_elem(32'hFFFF_FFFF, 1'b1);
        queue_elem(32'd1, 1'b0);
        queue_elem(32'd2, 1'b0);
        queue_elem(32'd3, 1'b1);
        queue_elem(-32'sd1, 1'b0);
        queue_elem(-32'sd2, 1'b0);
        queue_elem(-32'sd3, 1'b1);
        queue_elem(32'd1, 1'b0);
        queue_elem(32'd2, 1'b0);
        queue_elem(32'd3, 1'b0);
        queue_elem(-32'sd4, 1'b0);
        queue_elem(-32'sd5, 1'b0);
        queue_elem(-32'sd6, 1'b1);
        queue_elem(32'd0, 1'b0);
        queue_elem(32'd0, 1'b0);
        queue_elem(32'h8000_0000, 1'b1);

        // Full-size lists: one ended by the store filling up with the flag
        // clear, one with the flag on the 64th element.
        queue_list(LIST_CAP, 1'b0);
        queue_list(LIST_CAP, 1'b1);

        // Mostly short lists with random content and sign mix.
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 9) == 0)
                len = $urandom_range(13, 30);
            else
                len = $urandom_range(1, 12);
            queue_list(len, 1'b1);
            random_sent += len;
        end

        // Hold reset asserted, then release it on a falling edge.
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Drain: every item transferred, every expected result seen, then
        // a quiet spell to catch stray results.
        while (list_feed_q.size() != 0 || start)
            @(posedge clk);
        while (rearranged_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && rearranged_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Hard stop if the block hangs.
    initial
    begin
        #(LIMIT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
